// ----- rtl/look_at_basis_matrix_top_defines.svh -----
// Assertion helpers shared by the block's modules.
// Each macro expects clk and rst_n in scope.
`ifndef LOOK_AT_BASIS_MATRIX_TOP_DEFINES_SVH
`define LOOK_AT_BASIS_MATRIX_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define LAB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lab: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define LAB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lab: next-cycle check failed");

`endif

// ----- rtl/lab_pkg.sv -----
package lab_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int FRAC_BITS     = 16;
    localparam int MAX_FRAC_BITS = 24;
    localparam int QUEUE_DEPTH   = 2;
    localparam int VEC_W         = 64;
    localparam int UNIT_W        = MAX_FRAC_BITS + 3;
    localparam int DIFF_W        = COORD_WIDTH + 1;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [VEC_W-1:0]       vec_t;
    typedef logic signed [UNIT_W-1:0]      unit_t;
    typedef logic [1:0]                    col_t;

    localparam col_t COL_X = 2'd0;
    localparam col_t COL_Y = 2'd1;
    localparam col_t COL_Z = 2'd2;
    localparam col_t COL_T = 2'd3;

    typedef struct packed {
        coord_t aim_x;
        coord_t aim_y;
        coord_t aim_z;
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
        coord_t up_x;
        coord_t up_y;
        coord_t up_z;
    } item_t;

    typedef struct packed {
        col_t   column_index;
        coord_t comp_0;
        coord_t comp_1;
        coord_t comp_2;
        logic   degenerate;
        logic   last;
    } result_t;

    typedef struct packed {
        diff_t  diff_x;
        diff_t  diff_y;
        diff_t  diff_z;
        coord_t up_x;
        coord_t up_y;
        coord_t up_z;
        coord_t origin_x;
        coord_t origin_y;
        coord_t origin_z;
    } job_t;

    typedef struct packed {
        vec_t c0;
        vec_t c1;
        vec_t c2;
    } vec3_t;

    typedef struct packed {
        unit_t c0;
        unit_t c1;
        unit_t c2;
    } uvec3_t;

    typedef struct packed {
        logic  start;
        vec3_t v;
    } unit_ctl_t;

    typedef struct packed {
        logic done;
        logic ok;
    } unit_sts_t;

endpackage

// ----- rtl/look_at_basis_matrix_top.sv -----
// Look-at camera basis in signed fixed point.
// Request channel: item_valid / item_stall / item carry aim, origin and up; a
// request is taken at a rising edge with item_valid high and item_stall low.
// Result channel: result_valid / result_stall / result carry four columns per
// request in order x axis, y axis, z axis, translation; last marks the fourth.
// degenerate is the same on all four and zeroes the three axis columns.
// The front queues up to QUEUE_DEPTH requests with aim - origin formed; the back
// runs one request at a time through a single shared normalise unit, four passes
// per request, with a cross product before each of the last two.
// A pass runs 0 to 7 window shift steps, three square steps, a 32-step square
// root and FRAC_BITS + 1 divide steps; a zero length pass skips all of them.
// Reset empties the queue and idles both parts; nothing else needs clearing.
// A stalled result holds in the output register and the back holds its next
// column; item_stall rises while the queue is full.
module look_at_basis_matrix_top #(
    parameter int FRAC_BITS   = lab_pkg::FRAC_BITS,
    parameter int QUEUE_DEPTH = lab_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  lab_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output lab_pkg::result_t result
);

    logic               job_valid;
    lab_pkg::job_t      job;
    logic               pop;
    lab_pkg::unit_ctl_t ctl;
    lab_pkg::unit_sts_t sts;
    lab_pkg::uvec3_t    ures;

    // Front: accept requests and queue them with the exact difference vector.
    lab_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .pop        (pop),
        .job_valid  (job_valid),
        .job        (job)
    );

    // Shared normalize unit.
    lab_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts),
        .res   (ures)
    );

    // Back: sequence normalize passes and cross products, then drive columns.
    lab_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .pop          (pop),
        .ctl          (ctl),
        .sts          (sts),
        .ures         (ures),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// ----- rtl/lab_front.sv -----
module lab_front #(
    parameter int DEPTH = lab_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  lab_pkg::item_t item,
    input  logic           pop,
    output logic           job_valid,
    output lab_pkg::job_t  job
);

    `include "look_at_basis_matrix_top_defines.svh"

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lab_pkg::job_t     slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              do_pop;
    lab_pkg::job_t     new_job;

    assign item_stall = (count_reg == CNT_W'(DEPTH));
    assign job_valid  = (count_reg != '0);
    assign job        = slot_reg[rd_ptr_reg];
    assign push       = item_valid && !item_stall;
    assign do_pop     = pop && job_valid;

    // Classify: take aim - origin exactly, one bit wider than a coordinate.
    always_comb
    begin
        new_job.diff_x   = lab_pkg::diff_t'(item.aim_x) - lab_pkg::diff_t'(item.origin_x);
        new_job.diff_y   = lab_pkg::diff_t'(item.aim_y) - lab_pkg::diff_t'(item.origin_y);
        new_job.diff_z   = lab_pkg::diff_t'(item.aim_z) - lab_pkg::diff_t'(item.origin_z);
        new_job.up_x     = item.up_x;
        new_job.up_y     = item.up_y;
        new_job.up_z     = item.up_z;
        new_job.origin_x = item.origin_x;
        new_job.origin_y = item.origin_y;
        new_job.origin_z = item.origin_z;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_job;
        end
    end

    `LAB_ASSERT_NEXT(a_fill_grows, push && !do_pop, count_reg == $past(count_reg) + 1'b1)

endmodule

// ----- rtl/lab_unit.sv -----
module lab_unit #(
    parameter int FRAC_BITS = lab_pkg::FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  lab_pkg::unit_ctl_t ctl,
    output lab_pkg::unit_sts_t sts,
    output lab_pkg::uvec3_t    res
);

    `include "look_at_basis_matrix_top_defines.svh"

    localparam int VW         = lab_pkg::VEC_W;
    localparam int ROOT_STEPS = VW / 2;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam int QUO_W      = lab_pkg::UNIT_W - 1;
    localparam int WIN_EXP    = 29;

    typedef logic [VW-1:0] mag_t;

    localparam mag_t ONE       = mag_t'(1);
    localparam mag_t WIN_LO    = ONE << WIN_EXP;
    localparam mag_t WIN_HI    = ONE << (WIN_EXP + 1);
    localparam mag_t BIG_R16   = ONE << (WIN_EXP + 17);
    localparam mag_t BIG_R4    = ONE << (WIN_EXP + 5);
    localparam mag_t SMALL_L16 = ONE << (WIN_EXP - 16);
    localparam mag_t SMALL_L4  = ONE << (WIN_EXP - 4);

    typedef enum logic [6:0] {
        U_IDLE = 7'b0000001,
        U_NORM = 7'b0000010,
        U_SQ   = 7'b0000100,
        U_ROOT = 7'b0001000,
        U_PREP = 7'b0010000,
        U_DIV  = 7'b0100000,
        U_DONE = 7'b1000000
    } ustate_t;

    ustate_t           state_reg, state_next;
    logic              neg_reg [3], neg_next [3];
    mag_t              mag_reg [3], mag_next [3];
    mag_t              rem_reg [3], rem_next [3];
    logic [QUO_W-1:0]  quo_reg [3], quo_next [3];
    mag_t              top_reg, top_next;
    mag_t              acc_reg, acc_next;
    mag_t              root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              ok_reg, ok_next;

    lab_pkg::vec_t     vin [3];
    logic              neg_in [3];
    mag_t              mag_in [3];
    mag_t              top_in;
    mag_t              sq_sel;
    logic [WIN_EXP:0]  sq_op;
    logic [2*WIN_EXP+1:0] sq;
    mag_t              bitv;
    mag_t              trial;
    mag_t              dk;
    lab_pkg::unit_t    qv [3];

    always_comb
    begin
        vin[0] = ctl.v.c0;
        vin[1] = ctl.v.c1;
        vin[2] = ctl.v.c2;
        for (int i = 0; i < 3; i++)
        begin
            neg_in[i] = vin[i][VW-1];
            mag_in[i] = neg_in[i] ? mag_t'(-vin[i]) : mag_t'(vin[i]);
        end
        top_in = (mag_in[0] > mag_in[1]) ? mag_in[0] : mag_in[1];
        top_in = (mag_in[2] > top_in) ? mag_in[2] : top_in;

        sq_sel = mag_reg[cnt_reg[1:0]];
        sq_op  = sq_sel[WIN_EXP:0];
        sq     = sq_op * sq_op;

        bitv  = ONE << {cnt_reg, 1'b0};
        trial = root_reg + bitv;
        dk    = root_reg << cnt_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        top_next   = top_reg;
        acc_next   = acc_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        ok_next    = ok_reg;
        for (int i = 0; i < 3; i++)
        begin
            neg_next[i] = neg_reg[i];
            mag_next[i] = mag_reg[i];
            rem_next[i] = rem_reg[i];
            quo_next[i] = quo_reg[i];
        end

        unique case (state_reg)
            U_IDLE:
            begin
                if (ctl.start)
                begin
                    top_next = top_in;
                    for (int i = 0; i < 3; i++)
                    begin
                        neg_next[i] = neg_in[i];
                        mag_next[i] = mag_in[i];
                    end
                    if (top_in == '0)
                    begin
                        // Zero length: no unit vector, report and give zeros.
                        ok_next = 1'b0;
                        for (int i = 0; i < 3; i++)
                        begin
                            neg_next[i] = 1'b0;
                            quo_next[i] = '0;
                        end
                        state_next = U_DONE;
                    end
                    else
                    begin
                        ok_next    = 1'b1;
                        state_next = U_NORM;
                    end
                end
            end
            U_NORM:
            begin
                // Bring the largest magnitude into the window, coarse steps first.
                priority if (top_reg >= BIG_R16)
                begin
                    top_next = top_reg >> 16;
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 16;
                end
                else if (top_reg >= BIG_R4)
                begin
                    top_next = top_reg >> 4;
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 4;
                end
                else if (top_reg >= WIN_HI)
                begin
                    top_next = top_reg >> 1;
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] >> 1;
                end
                else if (top_reg < SMALL_L16)
                begin
                    top_next = top_reg << 16;
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] << 16;
                end
                else if (top_reg < SMALL_L4)
                begin
                    top_next = top_reg << 4;
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] << 4;
                end
                else if (top_reg < WIN_LO)
                begin
                    top_next = top_reg << 1;
                    for (int i = 0; i < 3; i++) mag_next[i] = mag_reg[i] << 1;
                end
                else
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = U_SQ;
                end
            end
            U_SQ:
            begin
                acc_next = acc_reg + mag_t'(sq);
                if (cnt_reg == CNT_W'(2))
                begin
                    cnt_next   = CNT_W'(ROOT_STEPS - 1);
                    root_next  = '0;
                    state_next = U_ROOT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            U_ROOT:
            begin
                if (acc_reg >= trial)
                begin
                    acc_next  = acc_reg - trial;
                    root_next = (root_reg >> 1) + bitv;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                if (cnt_reg == '0)
                begin
                    state_next = U_PREP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            U_PREP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_next[i] = (mag_reg[i] << FRAC_BITS) + (root_reg >> 1);
                    quo_next[i] = '0;
                end
                cnt_next   = CNT_W'(FRAC_BITS);
                state_next = U_DIV;
            end
            U_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (rem_reg[i] >= dk)
                    begin
                        rem_next[i] = rem_reg[i] - dk;
                        quo_next[i] = {quo_reg[i][QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next[i] = {quo_reg[i][QUO_W-2:0], 1'b0};
                    end
                end
                if (cnt_reg == '0)
                begin
                    state_next = U_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            U_DONE:
            begin
                state_next = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg  <= top_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        for (int i = 0; i < 3; i++)
        begin
            neg_reg[i] <= neg_next[i];
            mag_reg[i] <= mag_next[i];
            rem_reg[i] <= rem_next[i];
            quo_reg[i] <= quo_next[i];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qv[i] = lab_pkg::unit_t'({1'b0, quo_reg[i]});
            if (neg_reg[i])
            begin
                qv[i] = -qv[i];
            end
        end
        res.c0   = qv[0];
        res.c1   = qv[1];
        res.c2   = qv[2];
        sts.done = (state_reg == U_DONE);
        sts.ok   = ok_reg;
    end

    `LAB_ASSERT_SAME(a_zero_on_fail, sts.done && !sts.ok, res.c0 == '0 && res.c1 == '0 && res.c2 == '0)

endmodule

// ----- rtl/lab_back.sv -----
module lab_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  lab_pkg::job_t      job,
    output logic               pop,
    output lab_pkg::unit_ctl_t ctl,
    input  lab_pkg::unit_sts_t sts,
    input  lab_pkg::uvec3_t    ures,
    output logic               result_valid,
    input  logic               result_stall,
    output lab_pkg::result_t   result
);

    `include "look_at_basis_matrix_top_defines.svh"

    localparam int PROD_W = 2 * lab_pkg::UNIT_W;

    typedef enum logic [7:0] {
        B_IDLE = 8'b00000001,
        B_UY   = 8'b00000010,
        B_UU   = 8'b00000100,
        B_CX   = 8'b00001000,
        B_UX   = 8'b00010000,
        B_CZ   = 8'b00100000,
        B_UZ   = 8'b01000000,
        B_EMIT = 8'b10000000
    } bstate_t;

    bstate_t             state_reg, state_next;
    lab_pkg::job_t       job_reg, job_next;
    lab_pkg::uvec3_t     y_reg, y_next;
    lab_pkg::uvec3_t     u_reg, u_next;
    lab_pkg::uvec3_t     x_reg, x_next;
    lab_pkg::uvec3_t     z_reg, z_next;
    lab_pkg::vec_t       acc_reg, acc_next;
    lab_pkg::vec_t       crs0_reg, crs0_next;
    lab_pkg::vec_t       crs1_reg, crs1_next;
    logic [2:0]          ph_reg, ph_next;
    logic                ok_reg, ok_next;
    lab_pkg::col_t       beat_reg, beat_next;
    logic                ustart_reg, ustart_next;
    lab_pkg::vec3_t      uvec_reg, uvec_next;
    logic                out_valid_reg, out_valid_next;
    lab_pkg::result_t    out_reg, out_next;

    lab_pkg::unit_t      a_op [3];
    lab_pkg::unit_t      b_op [3];
    logic [1:0]          i1, i2;
    lab_pkg::unit_t      op_a, op_b;
    logic signed [PROD_W-1:0] prod;
    lab_pkg::vec_t       prod_ext;
    lab_pkg::vec_t       diff_last;
    logic                load;
    lab_pkg::result_t    col;

    assign pop          = (state_reg == B_IDLE) && job_valid;
    assign ctl.start    = ustart_reg;
    assign ctl.v        = uvec_reg;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign load         = (state_reg == B_EMIT) && (!out_valid_reg || !result_stall);

    // Cross product operands: y x u for the x axis, x x y for the z axis.
    always_comb
    begin
        if (state_reg == B_CX)
        begin
            a_op[0] = y_reg.c0; a_op[1] = y_reg.c1; a_op[2] = y_reg.c2;
            b_op[0] = u_reg.c0; b_op[1] = u_reg.c1; b_op[2] = u_reg.c2;
        end
        else
        begin
            a_op[0] = x_reg.c0; a_op[1] = x_reg.c1; a_op[2] = x_reg.c2;
            b_op[0] = y_reg.c0; b_op[1] = y_reg.c1; b_op[2] = y_reg.c2;
        end
        unique case (ph_reg[2:1])
            2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
            2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
            default: begin i1 = 2'd0; i2 = 2'd1; end
        endcase
        if (ph_reg[0])
        begin
            op_a = a_op[i2];
            op_b = b_op[i1];
        end
        else
        begin
            op_a = a_op[i1];
            op_b = b_op[i2];
        end
        prod      = op_a * op_b;
        prod_ext  = lab_pkg::vec_t'(prod);
        diff_last = acc_reg - prod_ext;
    end

    // Column for the current beat; axis columns drop to zero when degenerate.
    always_comb
    begin
        col.column_index = beat_reg;
        col.degenerate   = !ok_reg;
        col.last         = (beat_reg == lab_pkg::COL_T);
        unique case (beat_reg)
            lab_pkg::COL_X:
            begin
                col.comp_0 = lab_pkg::coord_t'(x_reg.c0);
                col.comp_1 = lab_pkg::coord_t'(x_reg.c1);
                col.comp_2 = lab_pkg::coord_t'(x_reg.c2);
            end
            lab_pkg::COL_Y:
            begin
                col.comp_0 = lab_pkg::coord_t'(y_reg.c0);
                col.comp_1 = lab_pkg::coord_t'(y_reg.c1);
                col.comp_2 = lab_pkg::coord_t'(y_reg.c2);
            end
            lab_pkg::COL_Z:
            begin
                col.comp_0 = lab_pkg::coord_t'(z_reg.c0);
                col.comp_1 = lab_pkg::coord_t'(z_reg.c1);
                col.comp_2 = lab_pkg::coord_t'(z_reg.c2);
            end
            default:
            begin
                col.comp_0 = job_reg.origin_x;
                col.comp_1 = job_reg.origin_y;
                col.comp_2 = job_reg.origin_z;
            end
        endcase
        if (!ok_reg && (beat_reg != lab_pkg::COL_T))
        begin
            col.comp_0 = '0;
            col.comp_1 = '0;
            col.comp_2 = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        y_next         = y_reg;
        u_next         = u_reg;
        x_next         = x_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        crs0_next      = crs0_reg;
        crs1_next      = crs1_reg;
        ph_next        = ph_reg;
        ok_next        = ok_reg;
        beat_next      = beat_reg;
        ustart_next    = 1'b0;
        uvec_next      = uvec_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (load)
        begin
            out_next       = col;
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (job_valid)
                begin
                    job_next     = job;
                    ok_next      = 1'b1;
                    ustart_next  = 1'b1;
                    uvec_next.c0 = lab_pkg::vec_t'(job.diff_x);
                    uvec_next.c1 = lab_pkg::vec_t'(job.diff_y);
                    uvec_next.c2 = lab_pkg::vec_t'(job.diff_z);
                    state_next   = B_UY;
                end
            end
            B_UY:
            begin
                if (sts.done)
                begin
                    y_next       = ures;
                    ok_next      = ok_reg && sts.ok;
                    ustart_next  = 1'b1;
                    uvec_next.c0 = lab_pkg::vec_t'(job_reg.up_x);
                    uvec_next.c1 = lab_pkg::vec_t'(job_reg.up_y);
                    uvec_next.c2 = lab_pkg::vec_t'(job_reg.up_z);
                    state_next   = B_UU;
                end
            end
            B_UU:
            begin
                if (sts.done)
                begin
                    u_next     = ures;
                    ok_next    = ok_reg && sts.ok;
                    ph_next    = '0;
                    state_next = B_CX;
                end
            end
            B_CX, B_CZ:
            begin
                // Even phase: first product; odd phase: subtract the second.
                ph_next = ph_reg + 1'b1;
                if (!ph_reg[0])
                begin
                    acc_next = prod_ext;
                end
                else if (ph_reg[2:1] == 2'd0)
                begin
                    crs0_next = diff_last;
                end
                else if (ph_reg[2:1] == 2'd1)
                begin
                    crs1_next = diff_last;
                end
                else
                begin
                    ustart_next  = 1'b1;
                    uvec_next.c0 = crs0_reg;
                    uvec_next.c1 = crs1_reg;
                    uvec_next.c2 = diff_last;
                    state_next   = (state_reg == B_CX) ? B_UX : B_UZ;
                end
            end
            B_UX:
            begin
                if (sts.done)
                begin
                    x_next     = ures;
                    ok_next    = ok_reg && sts.ok;
                    ph_next    = '0;
                    state_next = B_CZ;
                end
            end
            B_UZ:
            begin
                if (sts.done)
                begin
                    z_next     = ures;
                    ok_next    = ok_reg && sts.ok;
                    beat_next  = lab_pkg::COL_X;
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (load)
                begin
                    beat_next = beat_reg + 1'b1;
                    if (beat_reg == lab_pkg::COL_T)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ustart_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            ph_reg        <= '0;
            beat_reg      <= '0;
            ok_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ustart_reg    <= ustart_next;
            out_valid_reg <= out_valid_next;
            ph_reg        <= ph_next;
            beat_reg      <= beat_next;
            ok_reg        <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        y_reg    <= y_next;
        u_reg    <= u_next;
        x_reg    <= x_next;
        z_reg    <= z_next;
        acc_reg  <= acc_next;
        crs0_reg <= crs0_next;
        crs1_reg <= crs1_next;
        uvec_reg <= uvec_next;
        out_reg  <= out_next;
    end

    `LAB_ASSERT_SAME(a_done_expected, sts.done, state_reg == B_UY || state_reg == B_UU || state_reg == B_UX || state_reg == B_UZ)
    `LAB_ASSERT_NEXT(a_emit_ends, load && beat_reg == lab_pkg::COL_T, state_reg == B_IDLE)

endmodule
